// ===== rtl/rgbhsv_pkg.sv =====
// shared constants and types for the rgb to hsv converter
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

    localparam int COMPONENT_BITS_DEF    = 8;
    localparam int HUE_FRACTION_BITS_DEF = 6;

    // which component is largest; ties go red, then green
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

endpackage : rgbhsv_pkg

`default_nettype wire

// ===== rtl/rgb_to_hsv_convert.sv =====
// rgb to hsv converter: max/min stage, numerator stage, pipelined dividers, output stage
`timescale 1ns / 1ps
`default_nettype none

// Converts one rgb pixel per clock into hue, saturation and brightness.
// Input channel: red, green, blue with rgb_valid / rgb_ready.
// Output channel: hue, saturation, brightness with hsv_valid / hsv_ready.
// Hue is in 1/2^HUE_FRACTION_BITS degree, saturation full scale is 2^COMPONENT_BITS-1,
// brightness is the largest component.
// Both quotients come from restoring dividers that resolve one quotient bit per
// register stage, and the longer of the two sets the depth.
// Throughput is one pixel per clock whenever the receiver takes results.
// Every stage carries a valid bit and loads when it is empty or when the stage
// after it moves on, so bubbles close up and a stall at hsv_ready backs up
// stage by stage; the input is refused only once every stage holds a pixel.
// Reset clears all valid bits; the pipeline is then empty and ready at once.
module rgb_to_hsv_convert #(
    parameter int COMPONENT_BITS    = rgbhsv_pkg::COMPONENT_BITS_DEF,
    parameter int HUE_FRACTION_BITS = rgbhsv_pkg::HUE_FRACTION_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rgb_valid,
    output logic                                rgb_ready,
    input  wire logic [COMPONENT_BITS-1:0]      red,
    input  wire logic [COMPONENT_BITS-1:0]      green,
    input  wire logic [COMPONENT_BITS-1:0]      blue,
    output logic                                hsv_valid,
    input  wire logic                           hsv_ready,
    output logic [HUE_FRACTION_BITS+8:0]        hue,
    output logic [COMPONENT_BITS-1:0]           saturation,
    output logic [COMPONENT_BITS-1:0]           brightness
);

    import rgbhsv_pkg::*;

    localparam int W  = COMPONENT_BITS;
    localparam int HF = HUE_FRACTION_BITS;
    localparam int QB = HF + 6;             // hue quotient bits, quotient <= 60 << HF
    localparam int HW = HF + 9;
    localparam int D  = (QB > W) ? QB : W;  // divider stages

    localparam logic [HW-1:0] SECTOR_2 = HW'(120 << HF);
    localparam logic [HW-1:0] SECTOR_4 = HW'(240 << HF);
    localparam logic [HW-1:0] SECTOR_6 = HW'(360 << HF);

    typedef struct packed {
        logic [W-1:0]  max;
        logic [W-1:0]  diff;
        sector_t       sec;
        logic          neg;
        logic          grey;
        logic [W-1:0]  srem;
        logic [W-1:0]  slow;
        logic [W-1:0]  hrem;
        logic [QB-1:0] hlow;
    } div_t;

    // stage 1: max, min, sector
    logic          s1_valid_reg;
    logic [W-1:0]  s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [W-1:0]  s1_max_reg, s1_min_reg;
    sector_t       s1_sec_reg;
    logic [W-1:0]  s1_max_next, s1_min_next;
    sector_t       s1_sec_next;

    // stage 2: difference and signed numerator
    logic          s2_valid_reg;
    logic [W-1:0]  s2_max_reg, s2_diff_reg, s2_mag_reg;
    sector_t       s2_sec_reg;
    logic          s2_neg_reg;
    logic [W-1:0]  s2_opa, s2_opb;
    logic [W-1:0]  s2_mag_next;
    logic          s2_neg_next;

    // divider stages
    logic [D:0]    dv_valid_reg;
    div_t          dv_reg [0:D];
    div_t          dv_next [0:D];
    logic [D:0]    dv_adv;

    logic [W+QB-1:0] hnum;
    logic [2*W-1:0]  snum;

    // output register
    logic            hsv_valid_reg;
    logic [HW-1:0]   hue_reg, hue_next;
    logic [W-1:0]    sat_reg, bright_reg;
    logic [HW-1:0]   quot;

    logic s1_adv, s2_adv, out_adv;

    // request flow: a stage loads when empty or when the next one moves
    assign out_adv = !hsv_valid_reg || hsv_ready;
    assign dv_adv[D] = !dv_valid_reg[D] || out_adv;
    for (genvar k = 0; k < D; k++) begin : g_adv
        assign dv_adv[k] = !dv_valid_reg[k] || dv_adv[k+1];
    end
    assign s2_adv    = !s2_valid_reg || dv_adv[0];
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign rgb_ready = s1_adv;

    // stage 1
    always_comb
    begin
        s1_max_next = red;
        s1_min_next = red;
        if (green > s1_max_next)
        begin
            s1_max_next = green;
        end
        if (blue > s1_max_next)
        begin
            s1_max_next = blue;
        end
        if (green < s1_min_next)
        begin
            s1_min_next = green;
        end
        if (blue < s1_min_next)
        begin
            s1_min_next = blue;
        end
        if (red >= green && red >= blue)
        begin
            s1_sec_next = SEC_RED;
        end
        else if (green >= blue)
        begin
            s1_sec_next = SEC_GREEN;
        end
        else
        begin
            s1_sec_next = SEC_BLUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= rgb_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
            s1_max_reg   <= s1_max_next;
            s1_min_reg   <= s1_min_next;
            s1_sec_reg   <= s1_sec_next;
        end
    end

    // stage 2: numerator as sign and magnitude
    always_comb
    begin
        case (s1_sec_reg)
            SEC_RED:
            begin
                s2_opa = s1_green_reg;
                s2_opb = s1_blue_reg;
            end
            SEC_GREEN:
            begin
                s2_opa = s1_blue_reg;
                s2_opb = s1_red_reg;
            end
            SEC_BLUE:
            begin
                s2_opa = s1_red_reg;
                s2_opb = s1_green_reg;
            end
            default:
            begin
                s2_opa = s1_red_reg;
                s2_opb = s1_green_reg;
            end
        endcase
        s2_neg_next = s2_opa < s2_opb;
        s2_mag_next = s2_neg_next ? (s2_opb - s2_opa) : (s2_opa - s2_opb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_max_reg  <= s1_max_reg;
            s2_diff_reg <= s1_max_reg - s1_min_reg;
            s2_sec_reg  <= s1_sec_reg;
            s2_neg_reg  <= s2_neg_next;
            s2_mag_reg  <= s2_mag_next;
        end
    end

    // divider entry: hue numerator mag * 60 << HF, saturation numerator diff * full
    always_comb
    begin
        hnum = ({{QB{1'b0}}, s2_mag_reg} << QB) - ({{QB{1'b0}}, s2_mag_reg} << (HF + 2));
        snum = ({{W{1'b0}}, s2_diff_reg} << W) - {{W{1'b0}}, s2_diff_reg};
        dv_next[0].max  = s2_max_reg;
        dv_next[0].diff = s2_diff_reg;
        dv_next[0].sec  = s2_sec_reg;
        dv_next[0].neg  = s2_neg_reg;
        dv_next[0].grey = (s2_diff_reg == '0);
        dv_next[0].srem = snum[2*W-1:W];
        dv_next[0].slow = snum[W-1:0];
        dv_next[0].hrem = hnum[W+QB-1:QB];
        dv_next[0].hlow = hnum[QB-1:0];
    end

    // one restoring step per stage; both dividers finish in the last stage
    for (genvar k = 0; k < D; k++) begin : g_div
        logic [W:0] st, sd, ht, hd;

        always_comb
        begin
            dv_next[k+1] = dv_reg[k];
            st = {dv_reg[k].srem, dv_reg[k].slow[W-1]};
            sd = st - {1'b0, dv_reg[k].max};
            ht = {dv_reg[k].hrem, dv_reg[k].hlow[QB-1]};
            hd = ht - {1'b0, dv_reg[k].diff};
            if (k >= D - W)
            begin
                if (!sd[W])
                begin
                    dv_next[k+1].srem = sd[W-1:0];
                    dv_next[k+1].slow = {dv_reg[k].slow[W-2:0], 1'b1};
                end
                else
                begin
                    dv_next[k+1].srem = st[W-1:0];
                    dv_next[k+1].slow = {dv_reg[k].slow[W-2:0], 1'b0};
                end
            end
            if (k >= D - QB)
            begin
                if (!hd[W])
                begin
                    dv_next[k+1].hrem = hd[W-1:0];
                    dv_next[k+1].hlow = {dv_reg[k].hlow[QB-2:0], 1'b1};
                end
                else
                begin
                    dv_next[k+1].hrem = ht[W-1:0];
                    dv_next[k+1].hlow = {dv_reg[k].hlow[QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (dv_adv[0])
        begin
            dv_valid_reg[0] <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_adv[0])
        begin
            dv_reg[0] <= dv_next[0];
        end
    end

    for (genvar k = 1; k <= D; k++) begin : g_dvreg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            else if (dv_adv[k])
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (dv_adv[k])
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // output stage: place quotient in its sector
    always_comb
    begin
        quot = {{(HW-QB){1'b0}}, dv_reg[D].hlow};
        case (dv_reg[D].sec)
            SEC_RED:
            begin
                // a negative quotient that truncates to zero stays at zero
                if (dv_reg[D].neg && quot != '0)
                begin
                    hue_next = SECTOR_6 - quot;
                end
                else
                begin
                    hue_next = quot;
                end
            end
            SEC_GREEN:
            begin
                hue_next = dv_reg[D].neg ? (SECTOR_2 - quot) : (SECTOR_2 + quot);
            end
            SEC_BLUE:
            begin
                hue_next = dv_reg[D].neg ? (SECTOR_4 - quot) : (SECTOR_4 + quot);
            end
            default:
            begin
                hue_next = '0;
            end
        endcase
        if (dv_reg[D].grey)
        begin
            hue_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            hsv_valid_reg <= dv_valid_reg[D];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= dv_reg[D].grey ? '0 : dv_reg[D].slow;
            bright_reg <= dv_reg[D].max;
        end
    end

    assign hsv_valid  = hsv_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule : rgb_to_hsv_convert

`default_nettype wire
